### src/mcm_pkg.sv
// Shared constants and types of the multitrack clip manager.
package mcm_pkg;

    localparam int MAX_TRACKS  = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 12;
    localparam int TRACK_W     = 3;
    localparam int POLICY_W    = 3;
    localparam int IDX_W       = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int FILL_W      = $clog2(MAX_TRACKS + 1);
    localparam int SUM_W       = SAMPLE_BITS + IDX_W + 1;
    localparam int DIVD_W      = SAMPLE_BITS + FRAC_BITS;
    localparam int REM_W       = SUM_W - 1;
    localparam int CNT_W       = $clog2(DIVD_W + 1);

    localparam logic [POLICY_W-1:0] POL_NONE   = POLICY_W'(0);
    localparam logic [POLICY_W-1:0] POL_CLIP   = POLICY_W'(1);
    localparam logic [POLICY_W-1:0] POL_GLOBAL = POLICY_W'(2);
    localparam logic [POLICY_W-1:0] POL_TRACK  = POLICY_W'(3);
    localparam logic [POLICY_W-1:0] POL_FRAME  = POLICY_W'(4);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t Q_ONE   = sample_t'(1 << FRAC_BITS);
    localparam sample_t Q_M_ONE = sample_t'(-(1 << FRAC_BITS));
    localparam sample_t S_MAX   = sample_t'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam sample_t S_MIN   = sample_t'(-(1 << (SAMPLE_BITS - 1)));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_CLIP,
        OP_DIV
    } op_kind_t;

    typedef struct packed {
        logic accept;
        logic peak_upd;
        logic buf_wr;
        logic walk_begin;
        logic load;
        logic walk;
        logic div_step;
        logic emit;
        logic next_entry;
        logic frame_clear;
    } cmd_t;

    typedef struct packed {
        logic                mode;
        logic [POLICY_W-1:0] policy;
        logic                track_ok;
        logic                frame_end;
        logic                fill_almost;
        logic                load_div;
        logic                div_done;
        logic                out_free;
        logic                op_last;
    } status_t;

endpackage

### src/mcm_if.sv
// Valid/ready channel interfaces for sample items and result items.
interface mcm_in_if;
    import mcm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic                 block_start;
    logic [TRACK_W-1:0]   track;
    sample_t              wave_in;
    sample_t              amp_in;
    logic                 frame_end;

    modport source (output valid, mode, block_start, track, wave_in, amp_in, frame_end,
                    input ready);
    modport sink (input valid, mode, block_start, track, wave_in, amp_in, frame_end,
                  output ready);
endinterface

interface mcm_out_if;
    import mcm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TRACK_W-1:0]   track_out;
    sample_t              wave_out;
    sample_t              amp_out;
    logic                 last;

    modport source (output valid, track_out, wave_out, amp_out, last, input ready);
    modport sink (input valid, track_out, wave_out, amp_out, last, output ready);
endinterface

### src/mcm_ctrl.sv
// Control state machine of the multitrack clip manager.
module mcm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mcm_pkg::status_t status,
    output mcm_pkg::cmd_t    cmd
);
    import mcm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   walk_reg;
    logic   walk_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            walk_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        walk_next  = walk_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                walk_next = 1'b0;
                if (!status.track_ok)
                begin
                    state_next = ST_IDLE;
                end
                else if (!status.mode)
                begin
                    cmd.peak_upd = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (status.policy == POL_FRAME)
                begin
                    cmd.buf_wr = 1'b1;
                    if (status.frame_end || status.fill_almost)
                    begin
                        cmd.walk_begin = 1'b1;
                        walk_next      = 1'b1;
                        state_next     = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                cmd.walk   = walk_reg;
                state_next = status.load_div ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (walk_reg && !status.op_last)
                    begin
                        cmd.next_entry = 1'b1;
                        state_next     = ST_LOAD;
                    end
                    else
                    begin
                        cmd.frame_clear = walk_reg;
                        walk_next       = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/mcm_dp.sv
// Datapath: peak store, frame buffer, shared-divisor dividers and output register.
module mcm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcm_pkg::cmd_t                 cmd,
    output mcm_pkg::status_t              status,
    input  logic                          cfg_wr_en,
    input  logic [mcm_pkg::POLICY_W-1:0]  cfg_wr_data,
    input  logic                          in_mode,
    input  logic                          in_block_start,
    input  logic [mcm_pkg::TRACK_W-1:0]   in_track,
    input  mcm_pkg::sample_t              in_wave,
    input  mcm_pkg::sample_t              in_amp,
    input  logic                          in_frame_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mcm_pkg::TRACK_W-1:0]   out_track,
    output mcm_pkg::sample_t              out_wave,
    output mcm_pkg::sample_t              out_amp,
    output logic                          out_last
);
    import mcm_pkg::*;

    function automatic sample_t clip_one(input sample_t x);
        sample_t r;
        r = x;
        if (x > Q_ONE)
        begin
            r = Q_ONE;
        end
        else if (x < Q_M_ONE)
        begin
            r = Q_M_ONE;
        end
        return r;
    endfunction

    function automatic sample_t sat_quo(input logic neg, input logic [DIVD_W-1:0] q);
        sample_t r;
        if (neg)
        begin
            if (q >= (DIVD_W'(1) << (SAMPLE_BITS - 1)))
            begin
                r = S_MIN;
            end
            else
            begin
                r = -sample_t'(q[SAMPLE_BITS-1:0]);
            end
        end
        else
        begin
            if (q > DIVD_W'(S_MAX))
            begin
                r = S_MAX;
            end
            else
            begin
                r = sample_t'(q[SAMPLE_BITS-1:0]);
            end
        end
        return r;
    endfunction

    logic [POLICY_W-1:0]       policy_reg;
    logic                      mode_reg;
    logic                      start_reg;
    logic [TRACK_W-1:0]        track_reg;
    sample_t                   wave_reg;
    sample_t                   amp_reg;
    logic                      fend_reg;

    sample_t                   global_peak_reg;
    sample_t                   track_peak_reg [MAX_TRACKS];

    sample_t                   frame_wave [MAX_TRACKS];
    sample_t                   frame_amp [MAX_TRACKS];
    logic [TRACK_W-1:0]        frame_track [MAX_TRACKS];
    logic [FILL_W-1:0]         fill_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [IDX_W-1:0]          idx_reg;

    op_kind_t                  kind_reg;
    op_kind_t                  kind_next;
    logic [TRACK_W-1:0]        op_trk_reg;
    sample_t                   op_w_reg;
    sample_t                   op_a_reg;
    logic                      op_last_reg;
    sample_t                   src_w;
    sample_t                   src_a;
    logic [TRACK_W-1:0]        src_trk;
    logic                      src_last;
    sample_t                   peak_sel;
    logic [REM_W-1:0]          divisor_next;
    logic [REM_W-1:0]          divisor_reg;

    logic [DIVD_W-1:0]         quo_w_reg;
    logic [DIVD_W-1:0]         quo_a_reg;
    logic [REM_W-1:0]          rem_w_reg;
    logic [REM_W-1:0]          rem_a_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [REM_W:0]            trial_w;
    logic [REM_W:0]            trial_a;
    logic [SAMPLE_BITS-1:0]    mag_w;
    logic [SAMPLE_BITS-1:0]    mag_a;

    logic                      out_valid_reg;
    logic [TRACK_W-1:0]        out_track_reg;
    sample_t                   out_wave_reg;
    sample_t                   out_amp_reg;
    logic                      out_last_reg;
    sample_t                   res_w;
    sample_t                   res_a;
    logic [IDX_W-1:0]          trk_idx;
    sample_t                   g_base;

    assign trk_idx = track_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg  <= in_mode;
            start_reg <= in_block_start;
            track_reg <= in_track;
            wave_reg  <= in_wave;
            amp_reg   <= in_amp;
            fend_reg  <= in_frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_NONE;
        end
        else if (cfg_wr_en)
        begin
            policy_reg <= cfg_wr_data;
        end
    end

    assign g_base = start_reg ? '0 : global_peak_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_peak_reg <= '0;
            for (int i = 0; i < MAX_TRACKS; i++)
            begin
                track_peak_reg[i] <= '0;
            end
        end
        else if (cmd.peak_upd)
        begin
            global_peak_reg <= (amp_reg > g_base) ? amp_reg : g_base;
            for (int i = 0; i < MAX_TRACKS; i++)
            begin
                if (IDX_W'(i) == trk_idx)
                begin
                    if (amp_reg > (start_reg ? sample_t'(0) : track_peak_reg[i]))
                    begin
                        track_peak_reg[i] <= amp_reg;
                    end
                    else if (start_reg)
                    begin
                        track_peak_reg[i] <= '0;
                    end
                end
                else if (start_reg)
                begin
                    track_peak_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.buf_wr)
        begin
            frame_wave[fill_reg[IDX_W-1:0]]  <= wave_reg;
            frame_amp[fill_reg[IDX_W-1:0]]   <= amp_reg;
            frame_track[fill_reg[IDX_W-1:0]] <= track_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            sum_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en || cmd.frame_clear)
            begin
                fill_reg <= '0;
                sum_reg  <= '0;
            end
            else if (cmd.buf_wr)
            begin
                fill_reg <= fill_reg + 1'b1;
                sum_reg  <= sum_reg + SUM_W'(amp_reg);
            end
            if (cmd.walk_begin)
            begin
                idx_reg <= '0;
            end
            else if (cmd.next_entry)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        src_w        = wave_reg;
        src_a        = amp_reg;
        src_trk      = track_reg;
        src_last     = 1'b1;
        peak_sel     = '0;
        kind_next    = OP_PASS;
        divisor_next = '0;
        if (cmd.walk)
        begin
            src_w    = frame_wave[idx_reg];
            src_a    = frame_amp[idx_reg];
            src_trk  = frame_track[idx_reg];
            src_last = (FILL_W'(idx_reg) == fill_reg - 1'b1);
            if (sum_reg > SUM_W'(Q_ONE))
            begin
                kind_next    = OP_DIV;
                divisor_next = sum_reg[REM_W-1:0];
            end
        end
        else
        begin
            case (policy_reg)
                POL_CLIP:
                begin
                    kind_next = OP_CLIP;
                end
                POL_GLOBAL, POL_TRACK:
                begin
                    peak_sel = (policy_reg == POL_GLOBAL) ? global_peak_reg
                                                          : track_peak_reg[trk_idx];
                    divisor_next = REM_W'(peak_sel[SAMPLE_BITS-2:0]);
                    if (peak_sel != '0)
                    begin
                        kind_next = OP_DIV;
                    end
                end
                default:
                begin
                    kind_next = OP_PASS;
                end
            endcase
        end
    end

    assign mag_w   = src_w[SAMPLE_BITS-1] ? SAMPLE_BITS'(-src_w) : SAMPLE_BITS'(src_w);
    assign mag_a   = src_a[SAMPLE_BITS-1] ? SAMPLE_BITS'(-src_a) : SAMPLE_BITS'(src_a);
    assign trial_w = {rem_w_reg, quo_w_reg[DIVD_W-1]};
    assign trial_a = {rem_a_reg, quo_a_reg[DIVD_W-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= kind_next;
            op_trk_reg  <= src_trk;
            op_w_reg    <= src_w;
            op_a_reg    <= src_a;
            op_last_reg <= src_last;
            divisor_reg <= divisor_next;
            quo_w_reg   <= {mag_w, FRAC_BITS'(0)};
            quo_a_reg   <= {mag_a, FRAC_BITS'(0)};
            rem_w_reg   <= '0;
            rem_a_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (trial_w >= {1'b0, divisor_reg})
            begin
                rem_w_reg <= REM_W'(trial_w - {1'b0, divisor_reg});
                quo_w_reg <= {quo_w_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_w_reg <= trial_w[REM_W-1:0];
                quo_w_reg <= {quo_w_reg[DIVD_W-2:0], 1'b0};
            end
            if (trial_a >= {1'b0, divisor_reg})
            begin
                rem_a_reg <= REM_W'(trial_a - {1'b0, divisor_reg});
                quo_a_reg <= {quo_a_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_a_reg <= trial_a[REM_W-1:0];
                quo_a_reg <= {quo_a_reg[DIVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= CNT_W'(DIVD_W);
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        case (kind_reg)
            OP_CLIP:
            begin
                res_w = clip_one(op_w_reg);
                res_a = clip_one(op_a_reg);
            end
            OP_DIV:
            begin
                res_w = sat_quo(op_w_reg[SAMPLE_BITS-1], quo_w_reg);
                res_a = sat_quo(op_a_reg[SAMPLE_BITS-1], quo_a_reg);
            end
            default:
            begin
                res_w = op_w_reg;
                res_a = op_a_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_track_reg <= op_trk_reg;
            out_wave_reg  <= res_w;
            out_amp_reg   <= res_a;
            out_last_reg  <= op_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_track = out_track_reg;
    assign out_wave  = out_wave_reg;
    assign out_amp   = out_amp_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        status             = '0;
        status.mode        = mode_reg;
        status.policy      = policy_reg;
        status.track_ok    = (32'(track_reg) < MAX_TRACKS);
        status.frame_end   = fend_reg;
        status.fill_almost = (fill_reg == FILL_W'(MAX_TRACKS - 1));
        status.load_div    = (kind_next == OP_DIV);
        status.div_done    = (cnt_reg == '0);
        status.out_free    = !out_valid_reg || out_ready;
        status.op_last     = op_last_reg;
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_TRACKS))
        else $error("frame fill beyond track count");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (cnt_reg != '0))
        else $error("divider stepped past its last bit");

    a_walk_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && cmd.walk) |-> (FILL_W'(idx_reg) < fill_reg))
        else $error("frame walk beyond buffered items");

endmodule

### src/multitrack_clip_manager.sv
// Top level of the multitrack clip manager: controller plus datapath.
// Usage:
//   samples carries one track's wave/amplitude pair per item (valid/ready).
//   mode 0 items only update the global and per-track peaks; mode 1 items
//   produce results on the results channel according to clip_policy, which is
//   written through cfg_wr_en/cfg_wr_data; the user must write it only while
//   the block is idle, which the block itself does not enforce.
//   A pass-through or hard-clip item passes the decide, load and emit states
//   before its result lands in the output register; a scaled item adds the
//   divide state, the restoring divider resolving one quotient bit per cycle
//   for all 28 quotient bits (wave and amplitude in parallel).
//   A frame in anticlip mode is walked one buffered entry at a time, a full
//   frame holding up to 8 entries. A measure item updates the peaks in the decide state.
//   One item is worked on at a time; samples.ready is high only when idle.
//   Results wait in an output register; a stall on results holds the block
//   at its next emit without losing anything.
//   Reset clears policy, peaks, frame fill and all control state.
module multitrack_clip_manager (
    input  logic                         clk,
    input  logic                         rst_n,
    mcm_in_if.sink                       samples,
    mcm_out_if.source                    results,
    input  logic                         cfg_wr_en,
    input  logic [mcm_pkg::POLICY_W-1:0] cfg_wr_data
);
    import mcm_pkg::*;

    cmd_t    cmd;
    status_t status;

    mcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    mcm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_mode        (samples.mode),
        .in_block_start (samples.block_start),
        .in_track       (samples.track),
        .in_wave        (samples.wave_in),
        .in_amp         (samples.amp_in),
        .in_frame_end   (samples.frame_end),
        .out_valid      (results.valid),
        .out_ready      (results.ready),
        .out_track      (results.track_out),
        .out_wave       (results.wave_out),
        .out_amp        (results.amp_out),
        .out_last       (results.last)
    );

endmodule

### tb/sv/tb.sv
// Self-checking testbench of the multitrack clip manager: directed table, then random passes.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mcm_pkg::*;

    localparam logic MODE_MEASURE = 1'b0;
    localparam logic MODE_APPLY   = 1'b1;
    localparam logic [POLICY_W-1:0] POL_SPARE_LO = POLICY_W'(5);
    localparam logic [POLICY_W-1:0] POL_SPARE_HI = POLICY_W'(7);
    localparam int DRAIN_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic               mode;
        logic               start;
        logic [TRACK_W-1:0] trk;
        sample_t            wave;
        sample_t            amp;
        logic               fend;
    } sample_item_t;

    typedef struct {
        logic [TRACK_W-1:0] trk;
        sample_t            wave;
        sample_t            amp;
        logic               last;
    } clip_result_t;

    typedef struct {
        logic [POLICY_W-1:0] policy;
        sample_item_t        item;
        bit                  typed;
        clip_result_t        res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en;
    logic [POLICY_W-1:0] cfg_wr_data;

    mcm_in_if  smp ();
    mcm_out_if res ();

    multitrack_clip_manager dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (smp.sink),
        .results     (res.source),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [POLICY_W-1:0] pr_policy;
    longint              pr_gpeak;
    longint              pr_tpeak [MAX_TRACKS];
    longint              pr_fwave [MAX_TRACKS];
    longint              pr_famp  [MAX_TRACKS];
    logic [TRACK_W-1:0]  pr_ftrk  [MAX_TRACKS];
    int                  pr_fill;
    int                  pr_pushed = 0;

    clip_result_t expected_results [$];
    stim_row_t    dir_rows [$];
    int  errors = 0;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    longint cycles = 0;

    function automatic longint sat16(longint x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    function automatic longint div_scale(longint x, longint d);
        longint mag;
        longint q;
        mag = (x < 0) ? -x : x;
        q = (mag * 4096) / d;
        return sat16((x < 0) ? -q : q);
    endfunction

    function automatic void push_result(logic [TRACK_W-1:0] t, longint w, longint a, logic l);
        clip_result_t r;
        r.trk = t;
        r.wave = sample_t'(w);
        r.amp = sample_t'(a);
        r.last = l;
        expected_results.insert(expected_results.size(), r);
        pr_pushed++;
    endfunction

    function automatic void predict_clip(sample_item_t s);
        longint w;
        longint a;
        longint p;
        longint sum;
        w = s.wave;
        a = s.amp;
        if (s.mode == MODE_MEASURE)
        begin
            if (s.start)
            begin
                pr_gpeak = 0;
                foreach (pr_tpeak[i]) pr_tpeak[i] = 0;
            end
            if (a > pr_gpeak) pr_gpeak = a;
            if (a > pr_tpeak[s.trk]) pr_tpeak[s.trk] = a;
            return;
        end
        case (pr_policy)
            POL_CLIP:
            begin
                if (w > 4096) w = 4096;
                if (w < -4096) w = -4096;
                if (a > 4096) a = 4096;
                if (a < -4096) a = -4096;
                push_result(s.trk, w, a, 1'b1);
            end
            POL_GLOBAL, POL_TRACK:
            begin
                p = (pr_policy == POL_GLOBAL) ? pr_gpeak : pr_tpeak[s.trk];
                if (p > 0)
                begin
                    w = div_scale(w, p);
                    a = div_scale(a, p);
                end
                push_result(s.trk, w, a, 1'b1);
            end
            POL_FRAME:
            begin
                if (pr_fill >= MAX_TRACKS) pr_fill = 0;
                pr_fwave[pr_fill] = w;
                pr_famp[pr_fill] = a;
                pr_ftrk[pr_fill] = s.trk;
                pr_fill++;
                if (!s.fend && pr_fill < MAX_TRACKS) return;
                sum = 0;
                for (int i = 0; i < pr_fill; i++) sum += pr_famp[i];
                for (int i = 0; i < pr_fill; i++)
                begin
                    w = pr_fwave[i];
                    a = pr_famp[i];
                    if (sum > 4096)
                    begin
                        w = div_scale(w, sum);
                        a = div_scale(a, sum);
                    end
                    push_result(pr_ftrk[i], w, a, i + 1 == pr_fill);
                end
                pr_fill = 0;
            end
            default: push_result(s.trk, w, a, 1'b1);
        endcase
    endfunction

    task automatic send_item(sample_item_t s);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            smp.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        smp.valid       <= 1'b1;
        smp.mode        <= s.mode;
        smp.block_start <= s.start;
        smp.track       <= s.trk;
        smp.wave_in     <= s.wave;
        smp.amp_in      <= s.amp;
        smp.frame_end   <= s.fend;
        do @(posedge clk); while (!smp.ready);
        predict_clip(s);
    endtask

    task automatic write_policy(logic [POLICY_W-1:0] v);
        smp.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pr_policy = v;
        pr_fill = 0;
    endtask

    function automatic void add_row(logic [POLICY_W-1:0] pol, logic m, logic st,
                                    logic [TRACK_W-1:0] t, sample_t w, sample_t a, logic fe,
                                    bit typed = 0, logic [TRACK_W-1:0] et = '0,
                                    sample_t ew = '0, sample_t ea = '0);
        stim_row_t r;
        r.policy = pol;
        r.item = '{m, st, t, w, a, fe};
        r.typed = typed;
        r.res = '{et, ew, ea, 1'b1};
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(5))
            0: return S_MAX;
            1: return S_MIN;
            2: return sample_t'($urandom_range(1200));
            3: return -sample_t'($urandom_range(1200));
            default: return sample_t'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result trk=%0d wave=%h amp=%h last=%b", $realtime,
                         res.track_out, res.wave_out, res.amp_out, res.last);
            end
            else
            begin
                clip_result_t e;
                e = expected_results.pop_front();
                if (res.track_out !== e.trk || res.wave_out !== e.wave ||
                    res.amp_out !== e.amp || res.last !== e.last)
                begin
                    errors++;
                    $display("%0t: mismatch exp trk=%0d wave=%h amp=%h last=%b", $realtime,
                             e.trk, e.wave, e.amp, e.last);
                    $display("%0t:          act trk=%0d wave=%h amp=%h last=%b", $realtime,
                             res.track_out, res.wave_out, res.amp_out, res.last);
                end
            end
        end
        res.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    initial
    begin
        sample_item_t s;
        logic [POLICY_W-1:0] cur_pol;
        int n;
        int len;
        int before_cnt;

        smp.valid = 1'b0;
        smp.mode = 1'b0;
        smp.block_start = 1'b0;
        smp.track = '0;
        smp.wave_in = '0;
        smp.amp_in = '0;
        smp.frame_end = 1'b0;
        res.ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        pr_policy = POL_NONE;
        pr_gpeak = 0;
        foreach (pr_tpeak[i]) pr_tpeak[i] = 0;
        pr_fill = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(POL_NONE, MODE_APPLY, 0, 0, S_MAX, S_MIN, 1, 1, 0, S_MAX, S_MIN);
        add_row(POL_NONE, MODE_MEASURE, 1, 7, 0, Q_ONE, 0);
        add_row(POL_CLIP, MODE_APPLY, 0, 3, S_MAX, S_MIN, 0, 1, 3, Q_ONE, Q_M_ONE);
        add_row(POL_CLIP, MODE_APPLY, 0, 5, 16'sh0800, -16'sh0800, 1, 1, 5,
                16'sh0800, -16'sh0800);
        add_row(POL_GLOBAL, MODE_APPLY, 0, 1, 16'sh2000, 16'sh0800, 0);
        add_row(POL_GLOBAL, MODE_MEASURE, 1, 2, 0, -16'sh0005, 0);
        add_row(POL_GLOBAL, MODE_APPLY, 0, 2, 16'sh1234, 16'sh4321, 0, 1, 2,
                16'sh1234, 16'sh4321);
        add_row(POL_GLOBAL, MODE_MEASURE, 1, 4, 0, 16'sh0001, 0);
        add_row(POL_GLOBAL, MODE_APPLY, 0, 4, S_MAX, S_MIN, 0, 1, 4, S_MAX, S_MIN);
        add_row(POL_TRACK, MODE_MEASURE, 1, 0, 0, 16'sh2000, 0);
        add_row(POL_TRACK, MODE_MEASURE, 0, 1, 0, 16'sh0400, 0);
        add_row(POL_TRACK, MODE_APPLY, 0, 0, -16'sh3000, 16'sh1000, 0);
        add_row(POL_TRACK, MODE_APPLY, 0, 1, 16'sh0123, S_MIN, 0);
        add_row(POL_TRACK, MODE_APPLY, 0, 6, S_MIN, S_MAX, 0, 1, 6, S_MIN, S_MAX);
        add_row(POL_FRAME, MODE_APPLY, 0, 0, 16'sh0700, 16'sh0800, 0);
        add_row(POL_FRAME, MODE_APPLY, 0, 1, -16'sh0300, 16'sh0400, 1);
        add_row(POL_FRAME, MODE_APPLY, 0, 2, S_MAX, 16'sh1000, 0);
        add_row(POL_FRAME, MODE_MEASURE, 0, 3, 0, 16'sh1000, 0);
        add_row(POL_FRAME, MODE_APPLY, 0, 5, S_MIN, 16'sh1000, 1);
        for (int i = 0; i < MAX_TRACKS; i++)
            add_row(POL_FRAME, MODE_APPLY, 0, TRACK_W'(7 - i), S_MAX, 16'sh0900, 0);
        add_row(POL_FRAME, MODE_APPLY, 0, 3, 16'sh0100, 16'sh0100, 0);
        add_row(POL_SPARE_LO, MODE_APPLY, 0, 7, S_MAX, S_MIN, 0, 1, 7, S_MAX, S_MIN);
        add_row(POL_SPARE_HI, MODE_APPLY, 0, 6, S_MIN, S_MAX, 1, 1, 6, S_MIN, S_MAX);

        cur_pol = POL_NONE;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].policy != cur_pol)
            begin
                cur_pol = dir_rows[i].policy;
                write_policy(cur_pol);
            end
            before_cnt = pr_pushed;
            send_item(dir_rows[i].item);
            if (dir_rows[i].typed)
            begin
                n = pr_pushed - before_cnt;
                repeat (n) void'(expected_results.pop_back());
                expected_results.insert(expected_results.size(), dir_rows[i].res);
            end
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
                default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                write_policy(POLICY_W'(ph * 4 + seg));
                n = 0;
                while (n < 22)
                begin
                    len = $urandom_range(1, MAX_TRACKS);
                    case ($urandom_range(9))
                        0, 1, 2:
                            for (int k = 0; k < len; k++)
                            begin
                                s = '{MODE_MEASURE, k == 0, TRACK_W'($urandom),
                                      pick_sample(), pick_sample(), 1'($urandom)};
                                send_item(s);
                                n++;
                            end
                        8, 9:
                        begin
                            s = '{1'($urandom), 1'($urandom), TRACK_W'($urandom),
                                  sample_t'($urandom), sample_t'($urandom), 1'($urandom)};
                            send_item(s);
                            n++;
                        end
                        default:
                            for (int k = 0; k < len; k++)
                            begin
                                s = '{MODE_APPLY, 1'($urandom), TRACK_W'(k),
                                      pick_sample(), pick_sample(),
                                      (k == len - 1) && (len < MAX_TRACKS || $urandom_range(1))};
                                send_item(s);
                                n++;
                            end
                    endcase
                end
            end
        end

        smp.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

### filelist.f
src/mcm_pkg.sv
src/mcm_if.sv
src/mcm_ctrl.sv
src/mcm_dp.sv
src/multitrack_clip_manager.sv
tb/sv/tb.sv
